@@ hdl/mcr_pkg.sv @@
`default_nettype none

package mcr_pkg;

    // Input kinds carried on the slave-side tuser bit
    localparam logic OP_START   = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    // Eight symmetric copies per walk position
    localparam int OCT_W = 3;
    localparam logic [OCT_W-1:0] OCT_FIRST = 3'd0;
    localparam logic [OCT_W-1:0] OCT_LAST  = 3'd7;

    // Per-copy sign of the x offset, one bit per octant code (1 = subtract)
    localparam logic [7:0] NEG_X = 8'b0110_1010;
    // Per-copy sign of the y offset (1 = subtract)
    localparam logic [7:0] NEG_Y = 8'b1010_1100;

    // Control that travels with one walk position into the emitter
    typedef struct packed {
        logic pt_valid;   // position holds real pixels (clear on advance while idle)
        logic done;       // walk has ended after this item
    } t_emit_ctl;

    // Octants 4..7 swap the roles of x and y
    function automatic logic oct_swap(input logic [OCT_W-1:0] k);
        return k[OCT_W-1];
    endfunction

endpackage

`default_nettype wire

@@ hdl/mcr_walk.sv @@
`default_nettype none

module mcr_walk #(
    parameter int COORD_BITS = 12
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_load,
    input  wire                     i_opcode,
    input  wire [COORD_BITS-1:0]    i_center_x,
    input  wire [COORD_BITS-1:0]    i_center_y,
    input  wire [COORD_BITS-2:0]    i_radius,
    output logic [COORD_BITS-1:0]   o_cx,
    output logic [COORD_BITS-1:0]   o_cy,
    output logic [COORD_BITS-2:0]   o_x,
    output logic [COORD_BITS-2:0]   o_y,
    output mcr_pkg::t_emit_ctl      o_ctl
);
    import mcr_pkg::*;

    localparam int RAD_W = COORD_BITS - 1;
    localparam int DEC_W = COORD_BITS + 2;

    logic [COORD_BITS-1:0] r_cx, r_cy, n_cx, n_cy;
    logic [RAD_W-1:0]      r_x, r_y, n_x, n_y;
    logic [DEC_W-1:0]      r_dec, n_dec;
    logic                  r_active, n_active;

    logic [RAD_W-1:0] step_x, step_y;
    logic [DEC_W-1:0] x_ext, diff, inc, step_dec;
    logic             dec_neg, step_more;

    // One midpoint step from the current walk position
    always_comb begin
        dec_neg   = r_dec[DEC_W-1];
        step_x    = r_x + RAD_W'(1);
        step_y    = dec_neg ? r_y : (r_y - RAD_W'(1));
        x_ext     = DEC_W'(step_x);
        diff      = x_ext - DEC_W'(step_y);
        inc       = dec_neg ? {x_ext[DEC_W-2:0], 1'b1} : {diff[DEC_W-2:0], 1'b1};
        step_dec  = r_dec + inc;
        step_more = step_x < step_y;
    end

    // Select the next walk state and the control for the emitter
    always_comb begin
        n_cx       = r_cx;
        n_cy       = r_cy;
        n_x        = r_x;
        n_y        = r_y;
        n_dec      = r_dec;
        n_active   = r_active;
        o_ctl.pt_valid = 1'b0;
        o_ctl.done     = 1'b1;
        if (i_opcode == OP_START) begin
            n_cx     = i_center_x;
            n_cy     = i_center_y;
            n_x      = '0;
            n_y      = i_radius;
            n_dec    = DEC_W'(1) - DEC_W'(i_radius);
            n_active = i_radius != '0;
            o_ctl.pt_valid = 1'b1;
            o_ctl.done     = i_radius == '0;
        end else if (r_active) begin
            n_x      = step_x;
            n_y      = step_y;
            n_dec    = step_dec;
            n_active = step_more;
            o_ctl.pt_valid = 1'b1;
            o_ctl.done     = !step_more;
        end
    end

    assign o_cx = n_cx;
    assign o_cy = n_cy;
    assign o_x  = n_x;
    assign o_y  = n_y;

    // Commit the walk state on each input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx     <= '0;
            r_cy     <= '0;
            r_x      <= '0;
            r_y      <= '0;
            r_dec    <= '0;
            r_active <= 1'b0;
        end else if (i_load) begin
            r_cx     <= n_cx;
            r_cy     <= n_cy;
            r_x      <= n_x;
            r_y      <= n_y;
            r_dec    <= n_dec;
            r_active <= n_active;
        end
    end

endmodule

`default_nettype wire

@@ hdl/mcr_emit.sv @@
`default_nettype none

module mcr_emit #(
    parameter int COORD_BITS = 12
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_load,
    input  wire [COORD_BITS-1:0]      i_cx,
    input  wire [COORD_BITS-1:0]      i_cy,
    input  wire [COORD_BITS-2:0]      i_x,
    input  wire [COORD_BITS-2:0]      i_y,
    input  wire mcr_pkg::t_emit_ctl   i_ctl,
    output logic                      o_free,
    input  wire                       i_out_ready,
    output logic                      o_out_valid,
    output logic [COORD_BITS+1:0]     o_px,
    output logic [COORD_BITS+1:0]     o_py,
    output logic [mcr_pkg::OCT_W-1:0] o_oct,
    output logic                      o_pt_valid,
    output logic                      o_last,
    output logic                      o_done
);
    import mcr_pkg::*;

    localparam int RAD_W = COORD_BITS - 1;
    localparam int PT_W  = COORD_BITS + 2;

    // Held walk position and copy counter
    logic [COORD_BITS-1:0] r_cx, r_cy;
    logic [RAD_W-1:0]      r_x, r_y;
    t_emit_ctl             r_ctl;
    logic                  r_busy;
    logic [OCT_W-1:0]      r_k;

    // Output register
    logic                  r_out_valid;
    logic [PT_W-1:0]       r_px, r_py;
    logic [OCT_W-1:0]      r_oct;
    logic                  r_pv, r_last, r_done;

    logic             out_adv, gen, last_k;
    logic [RAD_W-1:0] dx, dy;
    logic [PT_W-1:0]  px, py, cx_ext, cy_ext, dx_ext, dy_ext;

    assign out_adv = !r_out_valid || i_out_ready;
    assign gen     = r_busy && out_adv;
    assign last_k  = !r_ctl.pt_valid || (r_k == OCT_LAST);
    assign o_free  = !r_busy || (gen && last_k);

    // Form the pixel for the current copy
    always_comb begin
        dx     = oct_swap(r_k) ? r_y : r_x;
        dy     = oct_swap(r_k) ? r_x : r_y;
        cx_ext = PT_W'(r_cx);
        cy_ext = PT_W'(r_cy);
        dx_ext = PT_W'(dx);
        dy_ext = PT_W'(dy);
        px     = NEG_X[r_k] ? (cx_ext - dx_ext) : (cx_ext + dx_ext);
        py     = NEG_Y[r_k] ? (cy_ext - dy_ext) : (cy_ext + dy_ext);
    end

    // Hold a walk position until all its copies have been registered for output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_k    <= OCT_FIRST;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_k    <= OCT_FIRST;
        end else if (gen && last_k) begin
            r_busy <= 1'b0;
        end else if (gen) begin
            r_k    <= r_k + OCT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_cx  <= i_cx;
            r_cy  <= i_cy;
            r_x   <= i_x;
            r_y   <= i_y;
            r_ctl <= i_ctl;
        end
    end

    // Advance the output register when it is empty or taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= gen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (gen) begin
            r_px   <= r_ctl.pt_valid ? px : '0;
            r_py   <= r_ctl.pt_valid ? py : '0;
            r_oct  <= r_ctl.pt_valid ? r_k : OCT_FIRST;
            r_pv   <= r_ctl.pt_valid;
            r_last <= last_k;
            r_done <= r_ctl.done;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_px        = r_px;
    assign o_py        = r_py;
    assign o_oct       = r_oct;
    assign o_pt_valid  = r_pv;
    assign o_last      = r_last;
    assign o_done      = r_done;

endmodule

`default_nettype wire

@@ hdl/midpoint_circle_rasterizer_core.sv @@
`default_nettype none

// Midpoint circle rasterizer. A start item (tuser = 0) loads centre and radius
// and yields the eight symmetric pixels of (0, radius); each advance item
// (tuser = 1) takes one midpoint step and yields the eight pixels of the new
// position in octant order 0..7, with tlast on octant 7. circle_done marks the
// step at which x reaches y; an advance with no circle in progress yields one
// empty result (point_valid 0, circle_done 1). A start or step item yields
// eight output beats, an empty advance one: the rate is set by the single
// output register, which sends one pixel per cycle unless m_axis_tready stalls
// it. The next item is taken in the cycle its predecessor's last pixel is
// registered, so a steady stream of items keeps the output busy every cycle.
module midpoint_circle_rasterizer_core #(
    parameter  int COORD_BITS = 12,
    localparam int IN_W  = ((3 * COORD_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((2 * (COORD_BITS + 2) + mcr_pkg::OCT_W + 7) / 8) * 8
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              s_axis_tvalid,
    output logic             s_axis_tready,
    // center_x, center_y, radius
    input  wire [IN_W-1:0]   s_axis_tdata,
    // opcode
    input  wire              s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire              m_axis_tready,
    // point_x, point_y, octant
    output logic [OUT_W-1:0] m_axis_tdata,
    // point_valid, circle_done
    output logic [1:0]       m_axis_tuser,
    // last_of_run
    output logic             m_axis_tlast
);
    import mcr_pkg::*;

    localparam int RAD_W = COORD_BITS - 1;
    localparam int PT_W  = COORD_BITS + 2;

    logic                  load, free;
    logic [COORD_BITS-1:0] cx, cy;
    logic [RAD_W-1:0]      wx, wy;
    t_emit_ctl             ctl;
    logic [PT_W-1:0]       px, py;
    logic [OCT_W-1:0]      oct;
    logic                  pt_valid, done;

    assign s_axis_tready = free;
    assign load          = s_axis_tvalid && free;

    mcr_walk #(
        .COORD_BITS (COORD_BITS)
    ) u_walk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_opcode   (s_axis_tuser),
        .i_center_x (s_axis_tdata[COORD_BITS-1:0]),
        .i_center_y (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .i_radius   (s_axis_tdata[3*COORD_BITS-2:2*COORD_BITS]),
        .o_cx       (cx),
        .o_cy       (cy),
        .o_x        (wx),
        .o_y        (wy),
        .o_ctl      (ctl)
    );

    mcr_emit #(
        .COORD_BITS (COORD_BITS)
    ) u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load),
        .i_cx        (cx),
        .i_cy        (cy),
        .i_x         (wx),
        .i_y         (wy),
        .i_ctl       (ctl),
        .o_free      (free),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_px        (px),
        .o_py        (py),
        .o_oct       (oct),
        .o_pt_valid  (pt_valid),
        .o_last      (m_axis_tlast),
        .o_done      (done)
    );

    assign m_axis_tdata = OUT_W'({oct, py, px});
    assign m_axis_tuser = {done, pt_valid};

    // A real pixel closes its run only on the last octant
    a_last_on_oct7: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && pt_valid && m_axis_tlast) |-> (oct == OCT_LAST))
        else $error("run closed before the last octant");

    // An empty result stands alone and reports the walk as ended
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !pt_valid) |-> (m_axis_tlast && done && oct == OCT_FIRST))
        else $error("empty result without tlast or done");

    // No item is taken while the held position still has copies to send
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready && pt_valid && !m_axis_tlast) |->
        !s_axis_tready)
        else $error("input taken mid-run");

    // Output is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

`default_nettype wire

@@ test/tb.sv @@
`default_nettype none

module tb;
    import mcr_pkg::*;

    localparam int IN_W        = 40;
    localparam int OUT_W       = 32;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int MAX_REPORTS = 10;
    localparam int DRAIN_WAIT  = 20;

    // x and y offset signs per octant code, in the block's octant order
    localparam int X_SIGN [8] = '{1, -1, 1, -1, 1, -1, -1, 1};
    localparam int Y_SIGN [8] = '{1, 1, -1, -1, 1, -1, 1, -1};

    typedef struct packed {
        logic [13:0] px;
        logic [13:0] py;
        logic [2:0]  oct;
        logic        pv;
        logic        last;
        logic        done;
    } t_pixel;

    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    wire              s_axis_tready;
    // center_x, center_y, radius
    logic [IN_W-1:0]  s_axis_tdata  = '0;
    // opcode
    logic             s_axis_tuser  = 1'b0;
    wire              m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    // point_x, point_y, octant
    wire [OUT_W-1:0]  m_axis_tdata;
    // point_valid, circle_done
    wire [1:0]        m_axis_tuser;
    // last_of_run
    wire              m_axis_tlast;

    // Circle walker state mirrored on the testbench side
    logic [11:0]        ctr_x   = '0;
    logic [11:0]        ctr_y   = '0;
    logic [10:0]        walk_x  = '0;
    logic [10:0]        walk_y  = '0;
    logic signed [13:0] dec_val = '0;
    logic               walking = 1'b0;

    t_pixel expected_pixels[$];
    int     mismatches    = 0;
    int     cycles        = 0;
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    int     hold_left     = 0;
    t_pixel got_px;
    t_pixel want_px;

    midpoint_circle_rasterizer_core #(.COORD_BITS(12)) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Drive the output ready: long hold-off when requested, random stalls otherwise
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare each output transfer against the oldest expected pixel
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_px = '{px: m_axis_tdata[13:0], py: m_axis_tdata[27:14],
                       oct: m_axis_tdata[30:28], pv: m_axis_tuser[0],
                       last: m_axis_tlast, done: m_axis_tuser[1]};
            if (expected_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected pixel x=%0d y=%0d oct=%0d pv=%b last=%b done=%b",
                             $signed(got_px.px), $signed(got_px.py), got_px.oct,
                             got_px.pv, got_px.last, got_px.done);
            end else begin
                want_px = expected_pixels.pop_front();
                if (got_px !== want_px) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $write("pixel mismatch: exp x=%0d y=%0d oct=%0d pv=%b last=%b done=%b",
                               $signed(want_px.px), $signed(want_px.py), want_px.oct,
                               want_px.pv, want_px.last, want_px.done);
                        $display(" | got x=%0d y=%0d oct=%0d pv=%b last=%b done=%b",
                                 $signed(got_px.px), $signed(got_px.py), got_px.oct,
                                 got_px.pv, got_px.last, got_px.done);
                    end
                end
            end
        end
    end

    // Queue the eight symmetric pixels of the current walk position
    task automatic push_octants(input logic fin);
        t_pixel p;
        int     dx;
        int     dy;
        for (int k = 0; k < 8; k++) begin
            dx     = (k < 4) ? int'(walk_x) : int'(walk_y);
            dy     = (k < 4) ? int'(walk_y) : int'(walk_x);
            p.px   = 14'(int'(ctr_x) + X_SIGN[k] * dx);
            p.py   = 14'(int'(ctr_y) + Y_SIGN[k] * dy);
            p.oct  = 3'(k);
            p.pv   = 1'b1;
            p.last = (3'(k) == OCT_LAST);
            p.done = fin;
            expected_pixels.push_back(p);
        end
    endtask

    // Advance the mirrored walker by one command and queue its pixels
    task automatic step_circle(input logic op, input logic [11:0] cx, input logic [11:0] cy,
                               input logic [10:0] r);
        t_pixel p;
        int     d;
        logic   fin;
        if (op == OP_START) begin
            ctr_x   = cx;
            ctr_y   = cy;
            walk_x  = '0;
            walk_y  = r;
            dec_val = 14'(1 - int'(r));
            fin     = !(walk_x < walk_y);
            walking = !fin;
            push_octants(fin);
        end else if (!walking) begin
            p = '{px: '0, py: '0, oct: OCT_FIRST, pv: 1'b0, last: 1'b1, done: 1'b1};
            expected_pixels.push_back(p);
        end else begin
            walk_x = walk_x + 11'd1;
            if (dec_val < 0) begin
                d = int'(dec_val) + 2 * int'(walk_x) + 1;
            end else begin
                walk_y = walk_y - 11'd1;
                d = int'(dec_val) + 2 * (int'(walk_x) - int'(walk_y)) + 1;
            end
            dec_val = 14'(d);
            fin     = !(walk_x < walk_y);
            if (fin)
                walking = 1'b0;
            push_octants(fin);
        end
    endtask

    // Offer one command after an optional random gap; return once it is transferred
    task automatic issue_cmd(input logic op, input logic [11:0] cx, input logic [11:0] cy,
                             input logic [10:0] r);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, r, cy, cx};
        s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        step_circle(op, cx, cy, r);
    endtask

    task automatic advance_rand();
        issue_cmd(OP_ADVANCE, 12'($urandom), 12'($urandom), 11'($urandom));
    endtask

    // Advance with no circle in flight right after reset
    task automatic test_idle_advance();
        advance_rand();
        advance_rand();
    endtask

    // Field extremes, zero and unit radius, restart mid-walk, negative coordinates
    task automatic test_directed();
        issue_cmd(OP_START, 12'd0, 12'd0, 11'd0);
        advance_rand();
        issue_cmd(OP_START, 12'd4095, 12'd4095, 11'd2047);
        repeat (3) advance_rand();
        // drop the big walk and start a tiny one
        issue_cmd(OP_START, 12'd4095, 12'd0, 11'd1);
        advance_rand();
        advance_rand();
        issue_cmd(OP_START, 12'd0, 12'd4095, 11'd2);
        while (walking)
            advance_rand();
        issue_cmd(OP_START, 12'd0, 12'd0, 11'd2047);
        repeat (4) advance_rand();
        issue_cmd(OP_START, 12'hAAA, 12'h555, 11'h555);
        issue_cmd(OP_START, 12'h555, 12'hAAA, 11'h2AA);
        advance_rand();
    endtask

    // Mostly complete walks of random circles, some cut short, plus stray commands
    task automatic test_random_walks(input int n_items);
        int         issued;
        int         abort_at;
        int         steps;
        logic [10:0] r;
        issued = 0;
        while (issued < n_items) begin
            if ($urandom_range(9) < 8) begin
                r = ($urandom_range(9) == 0) ? 11'($urandom_range(2047))
                                             : 11'($urandom_range(24));
                issue_cmd(OP_START, 12'($urandom), 12'($urandom), r);
                issued++;
                abort_at = ($urandom_range(6) == 0) ? $urandom_range(1, 6) : 30;
                steps = 0;
                while (walking && steps < abort_at) begin
                    advance_rand();
                    steps++;
                    issued++;
                end
                if ($urandom_range(3) == 0) begin
                    advance_rand();
                    issued++;
                end
            end else begin
                issue_cmd(1'($urandom), 12'($urandom), 12'($urandom), 11'($urandom));
                issued++;
            end
        end
    endtask

    // Hold the output off for a long stretch while a full walk is offered
    task automatic test_backpressure();
        hold_left = 300;
        issue_cmd(OP_START, 12'($urandom), 12'($urandom), 11'd12);
        while (walking)
            advance_rand();
    endtask

    // Full walk of a mid-size circle through to its end
    task automatic test_long_walk();
        issue_cmd(OP_START, 12'($urandom), 12'($urandom), 11'd40);
        while (walking)
            advance_rand();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 21;
        recv_idle_pct = 73;
        test_idle_advance();
        test_directed();
        test_random_walks(55);

        send_idle_pct = 73;
        recv_idle_pct = 21;
        test_backpressure();
        test_random_walks(55);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_walks(45);
        test_long_walk();

        s_axis_tvalid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
